// File: sv/ilist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ilist_pkg;

  localparam int DEPTH   = 256;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int MODE_W  = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND      = 3'd0,
    MODE_REMOVE_LAST = 3'd1,
    MODE_INSERT      = 3'd2,
    MODE_ERASE_ONE   = 3'd3,
    MODE_ERASE_RANGE = 3'd4,
    MODE_CLEAR       = 3'd5,
    MODE_READ        = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RD_LAST,
    RD_POS,
    RD_BELOW,
    RD_AHEAD
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_TAIL,
    WR_IDX_VALUE,
    WR_IDX_SHIFT
  } wr_sel_t;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_SUB_N,
    CNT_CLEAR
  } cnt_op_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_COUNT,
    IDX_LOAD_POS,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef struct packed {
    logic    load_req;
    logic    stat_load;
    logic    n_load;
    idx_op_t idx_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    cnt_op_t cnt_op;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    status_t           stat_now;
    logic              stat_ok_q;
    logic              idx_at_pos;
    logic              era_more;
    logic              out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/ilist_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ilist_req_if;
  logic                             valid;
  logic                             ready;
  logic [ilist_pkg::MODE_W-1:0]     mode;
  logic [ilist_pkg::ADDR_W-1:0]     position;
  logic [ilist_pkg::ADDR_W-1:0]     end_position;
  logic signed [ilist_pkg::VALUE_W-1:0] value;

  modport source (output valid, mode, position, end_position, value, input ready);
  modport sink (input valid, mode, position, end_position, value, output ready);
endinterface

interface ilist_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [ilist_pkg::VALUE_W-1:0] read_value;
  logic [ilist_pkg::CNT_W-1:0]      element_count;
  logic [1:0]                       status;

  modport source (output valid, read_value, element_count, status, input ready);
  modport sink (input valid, read_value, element_count, status, output ready);
endinterface

`default_nettype wire

// File: sv/ilist_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ilist_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ilist_pkg::sts_t sts,
  output ilist_pkg::cmd_t      cmd
);

  ilist_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilist_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ilist_pkg::S_IDLE: begin
        if (in_valid) state_next = ilist_pkg::S_DECIDE;
      end
      ilist_pkg::S_DECIDE: begin
        if (sts.stat_now != ilist_pkg::ST_OK) begin
          state_next = ilist_pkg::S_FINISH;
        end else begin
          case (sts.mode) inside
            ilist_pkg::MODE_INSERT, ilist_pkg::MODE_ERASE_ONE,
            ilist_pkg::MODE_ERASE_RANGE: state_next = ilist_pkg::S_SHIFT_RD;
            default:                     state_next = ilist_pkg::S_FINISH;
          endcase
        end
      end
      ilist_pkg::S_SHIFT_RD: begin
        if (sts.mode == ilist_pkg::MODE_INSERT) begin
          // final write of the new value happens here when idx reaches pos
          state_next = sts.idx_at_pos ? ilist_pkg::S_FINISH : ilist_pkg::S_SHIFT_WR;
        end else begin
          state_next = sts.era_more ? ilist_pkg::S_SHIFT_WR : ilist_pkg::S_FINISH;
        end
      end
      ilist_pkg::S_SHIFT_WR: begin
        state_next = ilist_pkg::S_SHIFT_RD;
      end
      ilist_pkg::S_FINISH: begin
        if (sts.out_free) state_next = ilist_pkg::S_IDLE;
      end
      default: state_next = ilist_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.idx_op    = ilist_pkg::IDX_HOLD;
    cmd.rd_sel    = ilist_pkg::RD_LAST;
    cmd.wr_sel    = ilist_pkg::WR_TAIL;
    cmd.cnt_op    = ilist_pkg::CNT_HOLD;
    unique case (state)
      ilist_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      ilist_pkg::S_DECIDE: begin
        cmd.stat_load = 1'b1;
        if (sts.stat_now == ilist_pkg::ST_OK) begin
          case (sts.mode) inside
            ilist_pkg::MODE_APPEND: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = ilist_pkg::WR_TAIL;
            end
            ilist_pkg::MODE_REMOVE_LAST: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ilist_pkg::RD_LAST;
            end
            ilist_pkg::MODE_READ: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ilist_pkg::RD_POS;
            end
            ilist_pkg::MODE_INSERT: begin
              cmd.idx_op = ilist_pkg::IDX_LOAD_COUNT;
            end
            ilist_pkg::MODE_ERASE_ONE, ilist_pkg::MODE_ERASE_RANGE: begin
              cmd.idx_op = ilist_pkg::IDX_LOAD_POS;
              cmd.n_load = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ilist_pkg::S_SHIFT_RD: begin
        if (sts.mode == ilist_pkg::MODE_INSERT) begin
          if (sts.idx_at_pos) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ilist_pkg::WR_IDX_VALUE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ilist_pkg::RD_BELOW;
          end
        end else if (sts.era_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ilist_pkg::RD_AHEAD;
        end
      end
      ilist_pkg::S_SHIFT_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ilist_pkg::WR_IDX_SHIFT;
        cmd.idx_op = (sts.mode == ilist_pkg::MODE_INSERT) ? ilist_pkg::IDX_DEC
                                                           : ilist_pkg::IDX_INC;
      end
      ilist_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.stat_ok_q) begin
            case (sts.mode) inside
              ilist_pkg::MODE_APPEND, ilist_pkg::MODE_INSERT:
                cmd.cnt_op = ilist_pkg::CNT_INC;
              ilist_pkg::MODE_REMOVE_LAST:
                cmd.cnt_op = ilist_pkg::CNT_DEC;
              ilist_pkg::MODE_ERASE_ONE, ilist_pkg::MODE_ERASE_RANGE:
                cmd.cnt_op = ilist_pkg::CNT_SUB_N;
              ilist_pkg::MODE_CLEAR:
                cmd.cnt_op = ilist_pkg::CNT_CLEAR;
              default:
                cmd.cnt_op = ilist_pkg::CNT_HOLD;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/ilist_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ilist_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire ilist_pkg::cmd_t                  cmd,
  output ilist_pkg::sts_t                       sts,
  input  wire logic [ilist_pkg::MODE_W-1:0]     mode,
  input  wire logic [ilist_pkg::ADDR_W-1:0]     position,
  input  wire logic [ilist_pkg::ADDR_W-1:0]     end_position,
  input  wire logic signed [ilist_pkg::VALUE_W-1:0] value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [ilist_pkg::VALUE_W-1:0]  read_value,
  output logic [ilist_pkg::CNT_W-1:0]           element_count,
  output logic [1:0]                            status
);

  localparam int CW = ilist_pkg::CNT_W;
  localparam int AW = ilist_pkg::ADDR_W;

  logic [ilist_pkg::VALUE_W-1:0] mem [ilist_pkg::DEPTH];
  logic [ilist_pkg::VALUE_W-1:0] rdata;

  logic [ilist_pkg::MODE_W-1:0] mode_q;
  logic [AW-1:0]                pos_q;
  logic [AW-1:0]                last_q;
  logic [ilist_pkg::VALUE_W-1:0] value_q;
  ilist_pkg::status_t           stat_q;
  ilist_pkg::status_t           stat_now;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] n;
  logic [CW:0]   ahead;
  logic [CW-1:0] below;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] wr_addr_full;
  logic [ilist_pkg::VALUE_W-1:0] wr_data;

  logic [CW-1:0] pos_ext, last_ext;
  assign pos_ext  = {1'b0, pos_q};
  assign last_ext = {1'b0, last_q};

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      mode_q  <= mode;
      pos_q   <= position;
      last_q  <= end_position;
      value_q <= value;
    end
    if (cmd.stat_load) stat_q <= stat_now;
    if (cmd.n_load) begin
      n <= (mode_q == ilist_pkg::MODE_ERASE_ONE) ? CW'(1) : CW'(last_ext - pos_ext + CW'(1));
    end
    idx <= idx_next;
  end

  // request checks against the current count
  always_comb begin
    stat_now = ilist_pkg::ST_OK;
    case (mode_q) inside
      ilist_pkg::MODE_APPEND: begin
        if (count == CW'(ilist_pkg::DEPTH)) stat_now = ilist_pkg::ST_FULL;
      end
      ilist_pkg::MODE_REMOVE_LAST: begin
        if (count == '0) stat_now = ilist_pkg::ST_EMPTY;
      end
      ilist_pkg::MODE_INSERT: begin
        if (pos_ext > count)                         stat_now = ilist_pkg::ST_RANGE;
        else if (count == CW'(ilist_pkg::DEPTH))     stat_now = ilist_pkg::ST_FULL;
      end
      ilist_pkg::MODE_ERASE_ONE, ilist_pkg::MODE_READ: begin
        if (count == '0)           stat_now = ilist_pkg::ST_EMPTY;
        else if (pos_ext >= count) stat_now = ilist_pkg::ST_RANGE;
      end
      ilist_pkg::MODE_ERASE_RANGE: begin
        if (count == '0)                                 stat_now = ilist_pkg::ST_EMPTY;
        else if (pos_q > last_q || last_ext >= count)    stat_now = ilist_pkg::ST_RANGE;
      end
      default: stat_now = ilist_pkg::ST_OK;
    endcase
  end

  assign ahead  = {1'b0, idx} + {1'b0, n};
  assign below  = idx - CW'(1);
  assign cnt_m1 = count - CW'(1);

  always_comb begin
    case (cmd.idx_op)
      ilist_pkg::IDX_LOAD_COUNT: idx_next = count;
      ilist_pkg::IDX_LOAD_POS:   idx_next = pos_ext;
      ilist_pkg::IDX_INC:        idx_next = idx + CW'(1);
      ilist_pkg::IDX_DEC:        idx_next = below;
      default:                   idx_next = idx;
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      ilist_pkg::RD_LAST:  rd_addr = cnt_m1[AW-1:0];
      ilist_pkg::RD_POS:   rd_addr = pos_q;
      ilist_pkg::RD_BELOW: rd_addr = below[AW-1:0];
      default:             rd_addr = ahead[AW-1:0];
    endcase
  end

  assign wr_addr_full = (cmd.wr_sel == ilist_pkg::WR_TAIL) ? count : idx;
  assign wr_addr      = wr_addr_full[AW-1:0];
  assign wr_data      = (cmd.wr_sel == ilist_pkg::WR_IDX_SHIFT) ? rdata : value_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rdata <= mem[rd_addr];
  end

  always_comb begin
    case (cmd.cnt_op)
      ilist_pkg::CNT_INC:   count_next = count + CW'(1);
      ilist_pkg::CNT_DEC:   count_next = cnt_m1;
      ilist_pkg::CNT_SUB_N: count_next = count - n;
      ilist_pkg::CNT_CLEAR: count_next = '0;
      default:              count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.out_load)    out_valid <= 1'b1;
      else if (out_ready)  out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      element_count <= count_next;
      status        <= stat_q;
      if (stat_q == ilist_pkg::ST_OK &&
          (mode_q == ilist_pkg::MODE_REMOVE_LAST || mode_q == ilist_pkg::MODE_READ)) begin
        read_value <= rdata;
      end else begin
        read_value <= '0;
      end
    end
  end

  assign sts.mode       = mode_q;
  assign sts.stat_now   = stat_now;
  assign sts.stat_ok_q  = (stat_q == ilist_pkg::ST_OK);
  assign sts.idx_at_pos = (idx == pos_ext);
  assign sts.era_more   = (ahead < {1'b0, count});
  assign sts.out_free   = !out_valid || out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ilist_pkg::DEPTH))
    else $error("element count above capacity");

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> wr_addr_full < CW'(ilist_pkg::DEPTH))
    else $error("memory write beyond capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

endmodule

`default_nettype wire

// File: sv/indexed_list_insert_erase.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to 256 signed 32-bit words held in a single RAM.
// req (sink): one beat per operation: mode, position, end_position, value.
//   Modes: append, remove last, insert, erase one, erase range, clear, read.
// rsp (source): one beat per request with read_value, element_count after
//   the operation, and status (ok, full, empty, position out of range).
//   A failed request leaves the list unchanged.
// Insert moves count - position entries and erase moves count - end - 1
//   entries, each with one RAM read and one RAM write; append, remove last,
//   read, clear and any failed request move none. One request is worked on
//   at a time, so no new request is taken before the result is loaded;
//   req.ready is high again the cycle after the result is loaded.
// The result sits in an output register, so the next request is taken while
// it waits; if rsp stalls, the following request finishes its work and then
// holds until the register is free.
// Reset clears the element count and the pending result; RAM contents are
// not cleared and need no clearing pass.
module indexed_list_insert_erase (
  input  wire logic   clk,
  input  wire logic   rst,
  ilist_req_if.sink   req,
  ilist_rsp_if.source rsp
);

  ilist_pkg::cmd_t cmd;
  ilist_pkg::sts_t sts;
  logic            in_ready;

  assign req.ready = in_ready;

  ilist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ilist_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (req.mode),
    .position      (req.position),
    .end_position  (req.end_position),
    .value         (req.value),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .read_value    (rsp.read_value),
    .element_count (rsp.element_count),
    .status        (rsp.status)
  );

endmodule

`default_nettype wire
